/* rtl/c2dm_pkg.sv */
// Shared types, codes and helpers for the mirrored-boundary 2D convolution block.
package c2dm_pkg;

  // Fixed field and register widths
  localparam int unsigned POS_W   = 6;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ISIZE_W = 7;
  localparam int unsigned KSIZE_W = 5;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CIDX_W  = 1;
  localparam int unsigned PROD_W  = 32;
  // Signed width of an image index before mirroring
  localparam int unsigned IDX_W   = 10;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CONV  = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_IMAGE_SIZE  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_KERNEL_SIZE = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Reflect an index into [0, size-1], then clamp what still falls outside
  function automatic logic [ISIZE_W-1:0] mirror_index(input logic signed [IDX_W-1:0] idx,
                                                      input logic [ISIZE_W-1:0] size);
    logic signed [IDX_W-1:0] m;
    logic signed [IDX_W-1:0] s;
    logic signed [IDX_W-1:0] top;
    s   = $signed(IDX_W'(size));
    top = s - $signed(IDX_W'(1));
    m   = idx;
    if (m < 0) begin
      m = -m;
    end
    if (m >= s) begin
      m = top + top - m;
    end
    if (m < 0) begin
      m = '0;
    end
    if (m > top) begin
      m = top;
    end
    return m[ISIZE_W-1:0];
  endfunction

endpackage

/* rtl/c2dm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c2dm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word into a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/conv2d_mirror_boundary.sv */
// Top level: 2D convolution with mirror boundary over a stored image and kernel.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  command | start, busy, cmd               | taken when start && !busy
//  result  | done, result                   | one-cycle strobe on done
//  config  | cfg_write, cfg_index, cfg_data | written when cfg_write is high
//
// A convolution request walks T = (2*floor(K/2))^2 taps through one shared
// multiply-accumulate, one tap a cycle. Each tap passes the address, RAM read,
// product and accumulate registers, and the result register holds the sum.
// A kernel below two skips the walk and goes straight to the drain state,
// with done in the cycle after busy. Reset is synchronous and clears the
// sequencer, valid flags and done and restores the size registers; store
// contents are undefined until written. Results cannot be stalled: each
// word shows on done for one cycle.
module conv2d_mirror_boundary #(
  parameter int unsigned MAX_IMAGE  = 64,
  parameter int unsigned MAX_KERNEL = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  c2dm_pkg::cmd_t                 cmd,
  output logic                           done,
  output c2dm_pkg::res_t                 result,
  input  logic                           cfg_write,
  input  logic [c2dm_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [c2dm_pkg::CFG_W-1:0]     cfg_data
);

  import c2dm_pkg::*;

  localparam int unsigned IMG_DEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int unsigned COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned IA_W = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int unsigned CA_W = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int unsigned KC_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned IMG_RST = (MAX_IMAGE < 64) ? MAX_IMAGE : 64;
  localparam int unsigned KER_RST = (MAX_KERNEL < 8) ? MAX_KERNEL : 8;

  state_t state;
  state_t state_next;

  logic [ISIZE_W-1:0] image_size;
  logic [KSIZE_W-1:0] kernel_size;
  logic [ISIZE_W-1:0] isize_next;
  logic [KSIZE_W-1:0] ksize_next;

  logic               accept;
  logic               img_we;
  logic               coef_we;
  logic [IA_W-1:0]    img_waddr;
  logic [CA_W-1:0]    coef_waddr;

  logic [POS_W-1:0]   run_row;
  logic [POS_W-1:0]   run_col;
  logic [KC_W-1:0]    ti;
  logic [KC_W-1:0]    tj;
  logic [KSIZE_W-1:0] span;
  logic [KC_W-1:0]    tap_last;
  logic [KSIZE_W-2:0] half;
  logic               issue;
  logic               row_end;
  logic               all_end;
  logic               pipe_empty;

  logic signed [IDX_W-1:0] xr;
  logic signed [IDX_W-1:0] yr;
  logic [ISIZE_W-1:0]      xi;
  logic [ISIZE_W-1:0]      yi;

  logic               a_valid;
  logic               r_valid;
  logic               p_valid;
  logic [IA_W-1:0]    img_raddr;
  logic [CA_W-1:0]    coef_raddr;
  logic [VALUE_W-1:0] img_rdata;
  logic [VALUE_W-1:0] coef_rdata;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Decode store writes; out-of-range positions are dropped
  always_comb begin
    img_we  = accept && (cmd.func == FUNC_PIXEL) &&
              (32'(cmd.row) < MAX_IMAGE) && (32'(cmd.col) < MAX_IMAGE);
    coef_we = accept && (cmd.func == FUNC_COEF) &&
              (32'(cmd.row) < MAX_KERNEL) && (32'(cmd.col) < MAX_KERNEL);
    img_waddr  = IA_W'(32'(cmd.row) * MAX_IMAGE + 32'(cmd.col));
    coef_waddr = CA_W'(32'(cmd.row) * MAX_KERNEL + 32'(cmd.col));
  end

  // Saturate configuration words into their legal ranges
  always_comb begin
    isize_next = cfg_data[ISIZE_W-1:0];
    if (isize_next < ISIZE_W'(2)) begin
      isize_next = ISIZE_W'(2);
    end
    if (32'(isize_next) > MAX_IMAGE) begin
      isize_next = ISIZE_W'(MAX_IMAGE);
    end
    ksize_next = cfg_data[KSIZE_W-1:0];
    if (ksize_next < KSIZE_W'(1)) begin
      ksize_next = KSIZE_W'(1);
    end
    if (32'(ksize_next) > MAX_KERNEL) begin
      ksize_next = KSIZE_W'(MAX_KERNEL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= ISIZE_W'(IMG_RST);
      kernel_size <= KSIZE_W'(KER_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_SIZE:  image_size  <= isize_next;
        REG_KERNEL_SIZE: kernel_size <= ksize_next;
        default: ;
      endcase
    end
  end

  // Tap span is the even part of the kernel size
  assign half     = kernel_size[KSIZE_W-1:1];
  assign span     = {half, 1'b0};
  assign tap_last = KC_W'(span - KSIZE_W'(1));
  assign row_end  = (tj == tap_last);
  assign all_end  = row_end && (ti == tap_last);
  assign pipe_empty = !a_valid && !r_valid && !p_valid;

  // Sequencer: next state and issue control
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd.func == FUNC_CONV)) begin
          state_next = (span == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (all_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and advance the tap counters
  always_ff @(posedge clk) begin
    if (accept && (cmd.func == FUNC_CONV)) begin
      run_row <= cmd.row;
      run_col <= cmd.col;
      ti      <= '0;
      tj      <= '0;
    end else if (issue) begin
      if (row_end) begin
        tj <= '0;
        ti <= ti + KC_W'(1);
      end else begin
        tj <= tj + KC_W'(1);
      end
    end
  end

  // Mirror the image indexes of the current tap
  always_comb begin
    xr = $signed(IDX_W'(run_row)) + $signed(IDX_W'(ti)) - $signed(IDX_W'(half));
    yr = $signed(IDX_W'(run_col)) + $signed(IDX_W'(tj)) - $signed(IDX_W'(half));
    xi = mirror_index(xr, image_size);
    yi = mirror_index(yr, image_size);
  end

  // Address stage
  always_ff @(posedge clk) begin
    img_raddr  <= IA_W'(32'(xi) * MAX_IMAGE + 32'(yi));
    coef_raddr <= CA_W'(32'(ti) * MAX_KERNEL + 32'(tj));
  end

  c2dm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (IMG_DEPTH)
  ) u_image_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (cmd.value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  c2dm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (cmd.value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Multiply, then accumulate the registered product
  always_ff @(posedge clk) begin
    prod <= $signed(img_rdata) * $signed(coef_rdata);
    if (accept && (cmd.func == FUNC_CONV)) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Track words through the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      r_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      a_valid <= issue;
      r_valid <= a_valid;
      p_valid <= r_valid;
    end
  end

  // Present the finished word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DRAIN) && pipe_empty;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DRAIN) && pipe_empty) begin
      result.out_row <= run_row;
      result.out_col <= run_col;
      result.sum     <= acc;
    end
  end

  // Checks on sequencer and pipe
  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DRAIN))
    else $error("result word without a drained pipe");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!a_valid && !r_valid && !p_valid))
    else $error("pipe busy while sequencer idle");

  a_conv_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.func == FUNC_CONV)) |=> (state != ST_IDLE))
    else $error("convolution request not started");

  a_taps_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((ti <= tap_last) && (tj <= tap_last)))
    else $error("tap counter beyond kernel span");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule
